### hw/rtl/msr_pkg.sv
// Shared constants for the modular square root block.
package msr_pkg;
  localparam int PRIME_WIDTH_DEF = 32;
  localparam int VALUE_W = 64;
  localparam int PORT_W = 32;
  localparam int COUNT_W = 2;

  localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic start;
    logic done;
  } msr_ctl_t;
endpackage

### hw/rtl/modular_square_root.sv
// Top level: Tonelli-Shanks modular square root sequencer.
//   channel  | handshake              | payload
//   cfg      | cfg_write              | cfg_data (square_value)
//   in       | in_valid / in_ready    | prime
//   out      | out_valid / out_ready  | root_count, first_root, second_root
// One item at a time. The value is first reduced modulo the prime bit-serially; each
// modular multiply runs in the bit-serial multiplier, and a modular power takes up to
// 2*PRIME_WIDTH multiplies. Euler test, one non-residue check and three powers when
// z is 2; a further candidate z adds a power, the loop up to about S*S multiplies.
// Synchronous reset clears control and the value register. A stalled result
// holds in the output register while the next item may already be taken.
module modular_square_root import msr_pkg::*; #(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [VALUE_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PORT_W-1:0]  prime,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] root_count,
  output logic [PORT_W-1:0]  first_root,
  output logic [PORT_W-1:0]  second_root
);
  localparam int W  = PRIME_WIDTH;
  localparam int CW = $clog2(PRIME_WIDTH + 1);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001, S_RED  = 17'h00002, S_EUL  = 17'h00004,
    S_FACT = 17'h00008, S_ZCHK = 17'h00010, S_GC   = 17'h00020,
    S_GR   = 17'h00040, S_GT   = 17'h00080, S_LOOP = 17'h00100,
    S_SQL  = 17'h00200, S_SQB  = 17'h00400, S_MR   = 17'h00800,
    S_MC   = 17'h01000, S_MT   = 17'h02000, S_PMUL = 17'h04000,
    S_PSQ  = 17'h08000, S_FIN  = 17'h10000
  } state_t;

  state_t state, ret;
  logic [VALUE_W-1:0] sqv;
  logic [W-1:0] p, a, half, q, z, c, r, t, tmp, b, pb, pe, pacc;
  logic [CW-1:0] s, m, i, k;
  logic [COUNT_W-1:0] fin_cnt;
  logic mul_run, mul_go, mul_done, mul_want;
  logic [W-1:0] mx, my, mres;
  msr_ctl_t red_ctl;
  logic red_done;
  logic [W-1:0] red_res;
  logic [W-1:0] p_in;
  logic [W:0] q_inc;

  assign p_in = prime[W-1:0];
  assign q_inc = ({1'b0, q} + 1'b1) >> 1;

  always_comb begin
    mul_want = 1'b0;
    mx = tmp;
    my = tmp;
    unique case (state)
      S_PMUL: begin
        mul_want = (pe != '0) && pe[0];
        mx = pacc;
        my = pb;
      end
      S_PSQ: begin
        mul_want = 1'b1;
        mx = pb;
        my = pb;
      end
      S_SQL: mul_want = (i < m) && (tmp != W'(1));
      S_SQB: begin
        mul_want = (k != '0);
        mx = b;
        my = b;
      end
      S_MR: begin
        mul_want = 1'b1;
        mx = r;
        my = b;
      end
      S_MC: begin
        mul_want = 1'b1;
        mx = b;
        my = b;
      end
      S_MT: begin
        mul_want = 1'b1;
        mx = t;
        my = c;
      end
      default: mul_want = 1'b0;
    endcase
    mul_go = mul_want && !mul_run;
  end

  assign red_ctl.start = (state == S_IDLE) && in_valid && (p_in > W'(2));
  assign red_ctl.done = red_done;

  msr_mulmod #(.PRIME_WIDTH(PRIME_WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .x(mx), .y(my), .m(p),
    .done(mul_done), .res(mres)
  );

  msr_reduce #(.PRIME_WIDTH(PRIME_WIDTH)) u_red (
    .clk(clk), .rst(rst), .ctl_in(red_ctl), .value(sqv), .m(p),
    .done(red_done), .res(red_res)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      sqv       <= '0;
      mul_run   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        sqv <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (mul_go) begin
        mul_run <= 1'b1;
      end else if (mul_done) begin
        mul_run <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            p <= p_in;
            r <= '0;
            fin_cnt <= CNT_NONE;
            if (p_in < W'(2)) begin
              state <= S_FIN;
            end else if (p_in == W'(2)) begin
              fin_cnt <= CNT_ONE;
              r <= W'(sqv[0]);
              state <= S_FIN;
            end else begin
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (red_done) begin
            a <= red_res;
            half <= (p - 1'b1) >> 1;
            pb <= red_res;
            pe <= (p - 1'b1) >> 1;
            pacc <= W'(1);
            ret <= S_EUL;
            state <= S_PMUL;
          end
        end
        S_EUL: begin
          if (pacc != W'(1)) begin
            state <= S_FIN;
          end else begin
            q <= p - 1'b1;
            s <= '0;
            state <= S_FACT;
          end
        end
        S_FACT: begin
          if (!q[0]) begin
            q <= q >> 1;
            s <= s + 1'b1;
          end else begin
            z <= W'(2);
            pb <= W'(2);
            pe <= half;
            pacc <= W'(1);
            ret <= S_ZCHK;
            state <= S_PMUL;
          end
        end
        S_ZCHK: begin
          pacc <= W'(1);
          state <= S_PMUL;
          if (pacc == W'(1)) begin
            z <= z + 1'b1;
            pb <= z + 1'b1;
            pe <= half;
            ret <= S_ZCHK;
            if (z + 1'b1 >= p) begin
              state <= S_FIN;
            end
          end else begin
            pb <= z;
            pe <= q;
            ret <= S_GC;
          end
        end
        S_GC: begin
          c <= pacc;
          pb <= a;
          pe <= q_inc[W-1:0];
          pacc <= W'(1);
          ret <= S_GR;
          state <= S_PMUL;
        end
        S_GR: begin
          r <= pacc;
          pb <= a;
          pe <= q;
          pacc <= W'(1);
          ret <= S_GT;
          state <= S_PMUL;
        end
        S_GT: begin
          t <= pacc;
          m <= s;
          state <= S_LOOP;
        end
        S_LOOP: begin
          if (t == W'(1)) begin
            fin_cnt <= (r != '0) ? CNT_TWO : CNT_ONE;
            state <= S_FIN;
          end else begin
            tmp <= t;
            i <= '0;
            state <= S_SQL;
          end
        end
        S_SQL: begin
          if (mul_want) begin
            if (mul_done) begin
              tmp <= mres;
              i <= i + 1'b1;
            end
          end else if (i >= m) begin
            r <= '0;
            state <= S_FIN;
          end else begin
            k <= m - i - 1'b1;
            b <= c;
            state <= S_SQB;
          end
        end
        S_SQB: begin
          if (mul_want) begin
            if (mul_done) begin
              b <= mres;
              k <= k - 1'b1;
            end
          end else begin
            state <= S_MR;
          end
        end
        S_MR: begin
          if (mul_done) begin
            r <= mres;
            state <= S_MC;
          end
        end
        S_MC: begin
          if (mul_done) begin
            c <= mres;
            state <= S_MT;
          end
        end
        S_MT: begin
          if (mul_done) begin
            t <= mres;
            m <= i;
            state <= S_LOOP;
          end
        end
        S_PMUL: begin
          if (pe == '0) begin
            state <= ret;
          end else if (!pe[0]) begin
            state <= S_PSQ;
          end else if (mul_done) begin
            pacc <= mres;
            state <= S_PSQ;
          end
        end
        S_PSQ: begin
          if (mul_done) begin
            pb <= mres;
            pe <= pe >> 1;
            state <= S_PMUL;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            root_count  <= fin_cnt;
            first_root  <= (fin_cnt == CNT_NONE) ? '0 : PORT_W'(r);
            second_root <= (fin_cnt == CNT_TWO) ? PORT_W'(p - r) : '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_roots_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && root_count == CNT_NONE) |-> (first_root == '0 && second_root == '0))
    else $error("zero-root item carries nonzero roots");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item accepted while busy");

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mul_run)
    else $error("multiplier running while idle");
endmodule

### hw/rtl/msr_mulmod.sv
// Bit-serial modular multiplier: x*y mod m, one bit of y per cycle, MSB first.
module msr_mulmod import msr_pkg::*; #(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PRIME_WIDTH-1:0] x,
  input  logic [PRIME_WIDTH-1:0] y,
  input  logic [PRIME_WIDTH-1:0] m,
  output logic                   done,
  output logic [PRIME_WIDTH-1:0] res
);
  localparam int CW = $clog2(PRIME_WIDTH + 1);

  logic                   busy;
  logic [CW-1:0]          cnt;
  logic [PRIME_WIDTH-1:0] ysh;
  logic [PRIME_WIDTH-1:0] xr;
  logic [PRIME_WIDTH-1:0] mr;
  logic [PRIME_WIDTH-1:0] acc;
  logic [PRIME_WIDTH:0]   dbl;
  logic [PRIME_WIDTH-1:0] dred;
  logic [PRIME_WIDTH:0]   sum;
  logic [PRIME_WIDTH-1:0] acc_next;

  always_comb begin
    dbl = {acc, 1'b0};
    if (dbl >= {1'b0, mr}) begin
      dbl = dbl - {1'b0, mr};
    end
    dred = dbl[PRIME_WIDTH-1:0];
    sum = {1'b0, dred} + (ysh[PRIME_WIDTH-1] ? {1'b0, xr} : '0);
    if (sum >= {1'b0, mr}) begin
      sum = sum - {1'b0, mr};
    end
    acc_next = sum[PRIME_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(PRIME_WIDTH);
        ysh  <= y;
        xr   <= x;
        mr   <= m;
        acc  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        ysh <= {ysh[PRIME_WIDTH-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = acc;
endmodule

### hw/rtl/msr_reduce.sv
// Bit-serial reduction of the 64-bit value modulo the prime.
module msr_reduce import msr_pkg::*; #(
  parameter int PRIME_WIDTH = PRIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  msr_ctl_t               ctl_in,
  input  logic [VALUE_W-1:0]     value,
  input  logic [PRIME_WIDTH-1:0] m,
  output logic                   done,
  output logic [PRIME_WIDTH-1:0] res
);
  localparam int VCW = $clog2(VALUE_W + 1);

  logic                   busy;
  logic [VCW-1:0]         cnt;
  logic [VALUE_W-1:0]     vsh;
  logic [PRIME_WIDTH-1:0] rem;
  logic [PRIME_WIDTH:0]   nxt;

  always_comb begin
    nxt = {rem, vsh[VALUE_W-1]};
    if (nxt >= {1'b0, m}) begin
      nxt = nxt - {1'b0, m};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
        cnt  <= VCW'(VALUE_W);
        vsh  <= value;
        rem  <= '0;
      end else if (busy) begin
        rem <= nxt[PRIME_WIDTH-1:0];
        vsh <= {vsh[VALUE_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == VCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = rem;
endmodule
